/* rtl/core/imhq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types, codes and defaults for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int ID_W         = 6;
  localparam int ID_SPACE     = 64;
  localparam int TIME_W       = 32;
  localparam int CNT_OUT_W    = 7;
  localparam int CNT_OUT_MAX  = 127;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_WIDTH_DEF = 32;

  typedef logic [1:0] req_t;
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_UPDATE = 2'd1;
  localparam req_t REQ_LOOKUP = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;
  localparam status_t ST_DUP    = 2'd3;

  // operand selection of the shared key comparator
  typedef enum logic [1:0] {
    CMP_UP   = 2'd0,  // moving key < parent key
    CMP_PICK = 2'd1,  // right key < left key
    CMP_DOWN = 2'd2   // child key < moving key
  } cmp_op_t;

endpackage

/* rtl/core/imhq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_in_if / imhq_out_if
// Valid/ready channels for requests and results of the heap queue.
// ----------------------------------------------------------------------------
interface imhq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  item_id;
  logic [31:0] time_key;

  modport source (output valid, req_type, item_id, time_key, input ready);
  modport sink   (input valid, req_type, item_id, time_key, output ready);
endinterface

interface imhq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        min_valid;
  logic [5:0]  min_id;
  logic [31:0] min_time;
  logic [31:0] found_time;
  logic [6:0]  entry_count;

  modport source (output valid, status, min_valid, min_id, min_time, found_time,
                  entry_count, input ready);
  modport sink   (input valid, status, min_valid, min_id, min_time, found_time,
                  entry_count, output ready);
endinterface

/* rtl/core/imhq_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_cmp
// Shared key comparator with operand selection per sift step.
// ----------------------------------------------------------------------------
module imhq_cmp import imhq_pkg::*; #(
  parameter int KW = KEY_WIDTH_DEF
) (
  input  cmp_op_t         op,
  input  logic [KW-1:0]   mov_key,
  input  logic [KW-1:0]   rd_key,
  input  logic [KW-1:0]   lft_key,
  input  logic [KW-1:0]   chd_key,
  output logic            lt
);

  logic [KW-1:0] a;
  logic [KW-1:0] b;

  always_comb begin
    case (op)
      CMP_UP: begin
        a = mov_key;
        b = rd_key;
      end
      CMP_PICK: begin
        a = rd_key;
        b = lft_key;
      end
      CMP_DOWN: begin
        a = chd_key;
        b = mov_key;
      end
      default: begin
        a = mov_key;
        b = mov_key;
      end
    endcase
  end

  assign lt = a < b;

endmodule

/* rtl/core/imhq_heap_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_heap_mem
// Heap slot storage (id, key); one write, one registered read, root copy.
// ----------------------------------------------------------------------------
module imhq_heap_mem import imhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KW       = KEY_WIDTH_DEF,
  parameter int AW       = 6
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output logic [ID_W-1:0] rd_id_r,
  output logic [KW-1:0]   rd_key_r,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [ID_W-1:0] wr_id,
  input  logic [KW-1:0]   wr_key,
  output logic [ID_W-1:0] root_id_r,
  output logic [KW-1:0]   root_key_r
);

  logic [ID_W-1:0] id_mem  [CAPACITY];
  logic [KW-1:0]   key_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      key_mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      rd_id_r  <= id_mem[rd_addr];
      rd_key_r <= key_mem[rd_addr];
    end
  end

  // root mirror, valid whenever the entry count is nonzero
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      root_id_r  <= wr_id;
      root_key_r <= wr_key;
    end
  end

endmodule

/* rtl/core/imhq_pos_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_pos_map
// Slot of each id, with per-id present bits cleared by reset.
// ----------------------------------------------------------------------------
module imhq_pos_map import imhq_pkg::*; #(
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [ID_W-1:0] rd_id,
  output logic [AW-1:0]   rd_pos_r,
  output logic            rd_present_r,
  input  logic            wr_en,
  input  logic [ID_W-1:0] wr_id,
  input  logic [AW-1:0]   wr_pos,
  input  logic            set_present
);

  logic [AW-1:0]       pos_mem [ID_SPACE];
  logic [ID_SPACE-1:0] present_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_id] <= wr_pos;
    end
    if (rd_en) begin
      rd_pos_r <= pos_mem[rd_id];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= '0;
      rd_present_r <= 1'b0;
    end else begin
      if (wr_en && set_present) begin
        present_r[wr_id] <= 1'b1;
      end
      if (rd_en) begin
        rd_present_r <= present_r[rd_id];
      end
    end
  end

endmodule

/* rtl/core/indexed_min_heap_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of ids keyed by event time, with sift sequencer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_chan   in   valid / ready    req_type, item_id, time_key
//  out_chan  out  valid / ready    status, min_valid, min_id, min_time,
//                                  found_time, entry_count
//
// One request at a time. Rejected requests and the unused code 3 go from
// decode straight to the result; a lookup reads the key of its slot first.
// Insert and a climbing update read the parent and compare per level
// climbed, then place the moving entry. Descending update, per level
// descended: left read, right read, pick, shift; the steps follow from the
// single read port of the heap memory and the one shared comparator. The
// result sits in an output register; a new request is taken once it is
// loaded, a stalled result only holds the sequencer at its last step. Reset
// is synchronous and clears the count and the present bits at once; no
// clearing pass.
//
module indexed_min_heap_queue import imhq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  imhq_in_if.sink    in_chan,
  imhq_out_if.source out_chan
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int KW = KEY_WIDTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DEC   = 11'b000_0000_0010,
    S_LK    = 11'b000_0000_0100,
    S_UP    = 11'b000_0000_1000,
    S_UPC   = 11'b000_0001_0000,
    S_DN    = 11'b000_0010_0000,
    S_DNL   = 11'b000_0100_0000,
    S_DNR   = 11'b000_1000_0000,
    S_DNS   = 11'b001_0000_0000,
    S_PLACE = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // request and working registers
  req_t            req_r;
  logic [ID_W-1:0] id_r;
  logic [KW-1:0]   key_r;
  status_t         status_r;
  logic [KW-1:0]   found_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   hole_r;      // slot the moving entry currently occupies
  logic            upd_r;       // update: try descent if no climb
  logic            moved_r;
  logic [ID_W-1:0] lft_id_r;
  logic [KW-1:0]   lft_key_r;
  logic [ID_W-1:0] chd_id_r;
  logic [KW-1:0]   chd_key_r;
  logic [AW-1:0]   chd_addr_r;

  // output register
  logic            out_valid_r;
  status_t         out_status_r;
  logic            out_min_valid_r;
  logic [ID_W-1:0] out_min_id_r;
  logic [TIME_W-1:0] out_min_time_r;
  logic [TIME_W-1:0] out_found_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  // memory ports
  logic            hp_rd_en;
  logic [AW-1:0]   hp_rd_addr;
  logic [ID_W-1:0] hp_rd_id;
  logic [KW-1:0]   hp_rd_key;
  logic            hp_wr_en;
  logic [ID_W-1:0] hp_wr_id;
  logic [KW-1:0]   hp_wr_key;
  logic [ID_W-1:0] root_id;
  logic [KW-1:0]   root_key;

  logic            pm_wr_en;
  logic [ID_W-1:0] pm_wr_id;
  logic            pm_set;
  logic [AW-1:0]   pm_pos;
  logic            pm_present;

  cmp_op_t cmp_op;
  logic    cmp_lt;

  logic in_fire;
  logic out_load;
  logic in_range;
  logic present;
  logic [AW-1:0] parent;
  logic [XW-1:0] lft_x;
  logic [XW-1:0] rgt_x;
  logic [XW-1:0] count_x;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign in_range = 32'(id_r) < 32'(CAPACITY);
  assign present  = in_range && pm_present;
  assign parent   = AW'((hole_r - AW'(1)) >> 1);
  assign lft_x    = (XW'(hole_r) << 1) + XW'(1);
  assign rgt_x    = (XW'(hole_r) << 1) + XW'(2);
  assign count_x  = XW'(count_r);

  imhq_heap_mem #(.CAPACITY(CAPACITY), .KW(KW), .AW(AW)) u_heap (
    .clk       (clk),
    .rd_en     (hp_rd_en),
    .rd_addr   (hp_rd_addr),
    .rd_id_r   (hp_rd_id),
    .rd_key_r  (hp_rd_key),
    .wr_en     (hp_wr_en),
    .wr_addr   (hole_r),
    .wr_id     (hp_wr_id),
    .wr_key    (hp_wr_key),
    .root_id_r (root_id),
    .root_key_r(root_key)
  );

  imhq_pos_map #(.AW(AW)) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_fire),
    .rd_id       (in_chan.item_id),
    .rd_pos_r    (pm_pos),
    .rd_present_r(pm_present),
    .wr_en       (pm_wr_en),
    .wr_id       (pm_wr_id),
    .wr_pos      (hole_r),
    .set_present (pm_set)
  );

  imhq_cmp #(.KW(KW)) u_cmp (
    .op     (cmp_op),
    .mov_key(key_r),
    .rd_key (hp_rd_key),
    .lft_key(lft_key_r),
    .chd_key(chd_key_r),
    .lt     (cmp_lt)
  );

  // sequencer and memory control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    hp_rd_en   = 1'b0;
    hp_rd_addr = parent;
    hp_wr_en   = 1'b0;
    hp_wr_id   = id_r;
    hp_wr_key  = key_r;
    pm_wr_en   = 1'b0;
    pm_wr_id   = id_r;
    pm_set     = 1'b0;
    cmp_op     = CMP_UP;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        case (req_r)
          REQ_INSERT: begin
            if (in_range && !present && (32'(count_r) < 32'(CAPACITY))) begin
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP;
            end
          end
          REQ_UPDATE: begin
            if (present) begin
              state_nxt = S_UP;
            end
          end
          REQ_LOOKUP: begin
            if (present) begin
              hp_rd_en   = 1'b1;
              hp_rd_addr = pm_pos;
              state_nxt  = S_LK;
            end
          end
          default: ;
        endcase
      end
      S_LK: begin
        state_nxt = S_DONE;
      end
      S_UP: begin
        if (hole_r == '0) begin
          state_nxt = (upd_r && !moved_r) ? S_DN : S_PLACE;
        end else begin
          hp_rd_en  = 1'b1;
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        cmp_op = CMP_UP;
        if (cmp_lt) begin
          // parent moves down into the hole
          hp_wr_en  = 1'b1;
          hp_wr_id  = hp_rd_id;
          hp_wr_key = hp_rd_key;
          pm_wr_en  = 1'b1;
          pm_wr_id  = hp_rd_id;
          state_nxt = S_UP;
        end else begin
          state_nxt = (upd_r && !moved_r) ? S_DN : S_PLACE;
        end
      end
      S_DN: begin
        if (lft_x < count_x) begin
          hp_rd_en   = 1'b1;
          hp_rd_addr = AW'(lft_x);
          state_nxt  = S_DNL;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DNL: begin
        if (rgt_x < count_x) begin
          hp_rd_en   = 1'b1;
          hp_rd_addr = AW'(rgt_x);
          state_nxt  = S_DNR;
        end else begin
          state_nxt = S_DNS;
        end
      end
      S_DNR: begin
        cmp_op    = CMP_PICK;
        state_nxt = S_DNS;
      end
      S_DNS: begin
        cmp_op = CMP_DOWN;
        if (cmp_lt) begin
          // smaller child moves up into the hole
          hp_wr_en  = 1'b1;
          hp_wr_id  = chd_id_r;
          hp_wr_key = chd_key_r;
          pm_wr_en  = 1'b1;
          pm_wr_id  = chd_id_r;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        hp_wr_en  = 1'b1;
        pm_wr_en  = 1'b1;
        pm_set    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_r    <= in_chan.req_type;
          id_r     <= in_chan.item_id;
          key_r    <= KW'(in_chan.time_key);
          status_r <= ST_OK;
          found_r  <= '0;
        end
      end
      S_DEC: begin
        upd_r   <= (req_r == REQ_UPDATE);
        moved_r <= 1'b0;
        case (req_r)
          REQ_INSERT: begin
            if (!in_range) begin
              status_r <= ST_ABSENT;
            end else if (present) begin
              status_r <= ST_DUP;
            end else if (32'(count_r) >= 32'(CAPACITY)) begin
              status_r <= ST_FULL;
            end else begin
              hole_r <= AW'(count_r);
            end
          end
          REQ_UPDATE, REQ_LOOKUP: begin
            if (!present) begin
              status_r <= ST_ABSENT;
            end else begin
              hole_r <= pm_pos;
            end
          end
          default: ;
        endcase
      end
      S_LK: begin
        found_r <= hp_rd_key;
      end
      S_UPC: begin
        if (cmp_lt) begin
          hole_r  <= parent;
          moved_r <= 1'b1;
        end
      end
      S_DNL: begin
        lft_id_r   <= hp_rd_id;
        lft_key_r  <= hp_rd_key;
        chd_id_r   <= hp_rd_id;
        chd_key_r  <= hp_rd_key;
        chd_addr_r <= AW'(lft_x);
      end
      S_DNR: begin
        // left wins ties
        if (cmp_lt) begin
          chd_id_r   <= hp_rd_id;
          chd_key_r  <= hp_rd_key;
          chd_addr_r <= AW'(rgt_x);
        end else begin
          chd_id_r   <= lft_id_r;
          chd_key_r  <= lft_key_r;
        end
      end
      S_DNS: begin
        if (cmp_lt) begin
          hole_r <= chd_addr_r;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r    <= status_r;
      out_min_valid_r <= (count_r != '0);
      out_min_id_r    <= (count_r != '0) ? root_id : '0;
      out_min_time_r  <= (count_r != '0) ? TIME_W'(root_key) : '0;
      out_found_r     <= TIME_W'(found_r);
      out_count_r     <= (32'(count_r) > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX)
                                                      : CNT_OUT_W'(count_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.min_valid   = out_min_valid_r;
  assign out_chan.min_id      = out_min_id_r;
  assign out_chan.min_time    = out_min_time_r;
  assign out_chan.found_time  = out_found_r;
  assign out_chan.entry_count = out_count_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DEC))
    else $error("accepted item not decoded");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    hp_wr_en |-> ((CW + 1)'(hole_r) < (CW + 1)'(count_r)))
    else $error("heap write beyond entry count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (status_r == ST_FULL)) |-> (32'(count_r) == 32'(CAPACITY)))
    else $error("full status with free slots");

endmodule

/* dv/imhq_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_tb_if
// Note: the channel interfaces come with the RTL (rtl/core/imhq_if.sv); this
// file only holds the request and result structs that the bench passes around.
// ----------------------------------------------------------------------------
package imhq_tb_pkg;
  import imhq_pkg::*;

  typedef struct packed {
    req_t        req;
    logic [5:0]  id;
    logic [31:0] key;
  } heap_req_t;

  typedef struct packed {
    status_t     status;
    logic        min_valid;
    logic [5:0]  min_id;
    logic [31:0] min_time;
    logic [31:0] found_time;
    logic [6:0]  entry_count;
  } heap_rsp_t;
endpackage

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed requests to the indexed min-heap queue; a shadow heap
// predicts every result, compared as a whole in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
  import imhq_pkg::*;
  import imhq_tb_pkg::*;

  localparam int CAP       = 64;
  localparam int N_RANDOM  = 2000;
  localparam int WDOG_MAX  = 5000;
  localparam int HOLD_LEN  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  imhq_in_if  in_chan();
  imhq_out_if out_chan();

  indexed_min_heap_queue dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  // ---- shadow heap -------------------------------------------------------
  logic [5:0]  sh_ids   [CAP];
  logic [31:0] sh_times [CAP];
  int          sh_pos   [64];
  bit          sh_here  [64];
  int          sh_count;

  heap_req_t   pending_q [$];
  heap_rsp_t   expect_q  [$];

  int  n_errors = 0;
  bit  hold_req;      // long receiver hold-off
  bit  calm;          // no idling stretch
  int  wdog;

  function automatic void swap_slots(int a, int b);
    logic [5:0]  tid;
    logic [31:0] tt;
    tid = sh_ids[a]; tt = sh_times[a];
    sh_ids[a] = sh_ids[b]; sh_times[a] = sh_times[b];
    sh_ids[b] = tid; sh_times[b] = tt;
    sh_pos[sh_ids[a]] = a;
    sh_pos[sh_ids[b]] = b;
  endfunction

  function automatic int climb(int i);
    int p;
    while (i != 0 && i < sh_count) begin
      p = (i - 1) / 2;
      if (!(sh_times[i] < sh_times[p])) break;
      swap_slots(i, p);
      i = p;
    end
    return i;
  endfunction

  function automatic void descend(int i);
    int l, r, s;
    while (i < sh_count) begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < sh_count && r < sh_count) s = (sh_times[l] > sh_times[r]) ? r : l;
      else if (l < sh_count) s = l;
      if (s == i || !(sh_times[i] > sh_times[s])) break;
      swap_slots(i, s);
      i = s;
    end
  endfunction

  // apply one request to the shadow heap and return the expected result
  function automatic heap_rsp_t heap_apply(heap_req_t rq);
    heap_rsp_t rs;
    bit        present;
    int        i;
    rs = '0;
    rs.status = ST_OK;
    present = sh_here[rq.id] && sh_pos[rq.id] < sh_count;
    case (rq.req)
      REQ_INSERT: begin
        if (present) rs.status = ST_DUP;
        else if (sh_count >= CAP) rs.status = ST_FULL;
        else begin
          i = sh_count;
          sh_count++;
          sh_ids[i] = rq.id;
          sh_times[i] = rq.key;
          sh_pos[rq.id] = i;
          sh_here[rq.id] = 1'b1;
          void'(climb(i));
        end
      end
      REQ_UPDATE: begin
        if (!present) rs.status = ST_ABSENT;
        else begin
          i = sh_pos[rq.id];
          sh_times[i] = rq.key;
          if (climb(i) == i) descend(i);
        end
      end
      REQ_LOOKUP: begin
        if (!present) rs.status = ST_ABSENT;
        else rs.found_time = sh_times[sh_pos[rq.id]];
      end
      default: ;  // unused code: no change
    endcase
    rs.min_valid = (sh_count > 0);
    rs.min_id = (sh_count > 0) ? sh_ids[0] : '0;
    rs.min_time = (sh_count > 0) ? sh_times[0] : '0;
    rs.entry_count = 7'(sh_count);
    return rs;
  endfunction

  // ---- driver --------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid    <= 1'b0;
      in_chan.req_type <= '0;
      in_chan.item_id  <= '0;
      in_chan.time_key <= '0;
    end else begin
      // item taken at this edge: prediction happens here, in order of acceptance
      if (in_chan.valid && in_chan.ready) begin
        expect_q.push_back(heap_apply(pending_q.pop_front()));
      end
      if ((!in_chan.valid || in_chan.ready) || !in_chan.valid) begin
        if (in_chan.valid && !in_chan.ready) begin
          // hold current item
        end else if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
          in_chan.valid    <= 1'b1;
          in_chan.req_type <= pending_q[0].req;
          in_chan.item_id  <= pending_q[0].id;
          in_chan.time_key <= pending_q[0].key;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver / monitor --------------------------------------------------
  always @(posedge clk) begin
    heap_rsp_t got, exp_rs;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.status, out_chan.min_valid, out_chan.min_id,
                out_chan.min_time, out_chan.found_time, out_chan.entry_count};
        if (expect_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_rs = expect_q.pop_front();
          if (got !== exp_rs) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: exp %p got %p", exp_rs, got);
          end
        end
      end
      out_chan.ready <= !hold_req && (calm || $urandom_range(99) >= 18);
    end
  end

  // ---- watchdog ------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || hold_req)
      wdog <= 0;
    else if (pending_q.size() > 0 || expect_q.size() > 0) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------
  function automatic heap_req_t mk(req_t r, int id, logic [31:0] k);
    heap_req_t q;
    q.req = r; q.id = id[5:0]; q.key = k;
    return q;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || expect_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int k, r;
    logic [31:0] key;
    hold_req = 0; calm = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: absent id on empty heap, unused code, extremes, dup, tie
    pending_q.push_back(mk(REQ_LOOKUP, 0, 32'h0));
    pending_q.push_back(mk(REQ_UPDATE, 63, 32'hFFFF_FFFF));
    pending_q.push_back(mk(req_t'(2'd3), 5, 32'h1234));
    pending_q.push_back(mk(REQ_INSERT, 63, 32'hFFFF_FFFF));
    pending_q.push_back(mk(REQ_INSERT, 0, 32'h0));
    pending_q.push_back(mk(REQ_INSERT, 0, 32'h5));          // duplicate
    pending_q.push_back(mk(REQ_INSERT, 1, 32'h10));
    pending_q.push_back(mk(REQ_INSERT, 2, 32'h10));          // equal children
    pending_q.push_back(mk(REQ_UPDATE, 0, 32'h20));          // sink root, left pick
    pending_q.push_back(mk(REQ_UPDATE, 63, 32'h0));          // climb to root
    pending_q.push_back(mk(REQ_LOOKUP, 63, 32'h0));
    pending_q.push_back(mk(REQ_LOOKUP, 1, 32'hAAAA_5555));
    pending_q.push_back(mk(req_t'(2'd3), 63, 32'hFFFF_FFFF));
    drain();
    // fill to capacity, then update an id to the largest key
    for (k = 0; k < 64; k++) pending_q.push_back(mk(REQ_INSERT, k, $urandom));
    pending_q.push_back(mk(REQ_UPDATE, 10, 32'hFFFF_FFFF));
    drain();
    // long hold-off with the sender still offering, heap is full
    calm = 1;
    for (k = 0; k < 40; k++) pending_q.push_back(mk(REQ_INSERT, $urandom_range(63), $urandom));
    hold_req = 1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_req = 0;
    drain();
    calm = 0;

    // random: mostly updates and lookups on ids in play; occasional resets of
    // the population are impossible, so a small key range keeps ties common
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == 800) calm = 1;
      if (k == 1100) calm = 0;
      r = $urandom_range(99);
      key = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom;
      if (r < 20)      pending_q.push_back(mk(REQ_INSERT, $urandom_range(63), key));
      else if (r < 70) pending_q.push_back(mk(REQ_UPDATE, $urandom_range(63), key));
      else if (r < 95) pending_q.push_back(mk(REQ_LOOKUP, $urandom_range(63), key));
      else             pending_q.push_back(mk(req_t'(2'd3), $urandom_range(63), key));
      if (pending_q.size() > 30) while (pending_q.size() > 5) @(posedge clk);
    end
    drain();

    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* files.f */
rtl/core/imhq_pkg.sv
rtl/core/imhq_if.sv
rtl/core/imhq_cmp.sv
rtl/core/imhq_heap_mem.sv
rtl/core/imhq_pos_map.sv
rtl/core/indexed_min_heap_queue.sv
dv/imhq_tb_if.sv
dv/tb_top.sv
